// ===== hw/rtl/fixed_matrix_vector_stream_unit_defines.svh =====
// assertion macros shared by the matrix vector stream unit
`ifndef FIXED_MATRIX_VECTOR_STREAM_UNIT_DEFINES_SVH
`define FIXED_MATRIX_VECTOR_STREAM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define FMVS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define FMVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FMVS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FMVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/fmvs_pkg.sv =====
// types, constants and scaling function of the matrix vector stream unit
package fmvs_pkg;

    localparam int COEFF_DEPTH = 64;
    localparam int COEFF_AW    = 6;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 3;
    localparam int SIZE_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE    = 2'd1;

    // item modes
    localparam logic MODE_COEFF = 1'b0;
    localparam logic MODE_ELEM  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              transpose;
    } fmvs_cfg_t;

    // classified item travelling from front to back
    typedef struct packed {
        logic                     mode;
        logic [COEFF_AW-1:0]      coeff_index;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         elem_idx;
        logic                     done;
        logic                     flush;
        logic [POS_W-1:0]         last_pos;
    } fmvs_item_t;

    // finished vector handed from back to result stage
    typedef struct packed {
        logic             valid;
        logic             flush;
        logic [POS_W-1:0] last_pos;
    } fmvs_done_t;

    // drop fraction bits (floor) and saturate to 32 bits
    function automatic logic [DATA_W-1:0] scale_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_BITS-1:0]        sh;
        logic [ACC_W-FRAC_BITS-DATA_W:0]   hi;
        logic [DATA_W-1:0]                 res;
        sh = acc[ACC_W-1:FRAC_BITS];
        hi = sh[ACC_W-FRAC_BITS-1:DATA_W-1];
        if ((&hi) || !(|hi))
        begin
            res = sh[DATA_W-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/fmvs_front.sv =====
// front: tracks the element count and classifies each accepted item
`include "fixed_matrix_vector_stream_unit_defines.svh"

module fmvs_front
    import fmvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     mode,
    input  logic [COEFF_AW-1:0]      coeff_index,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     stream_last,
    input  fmvs_cfg_t                cfg,
    output fmvs_item_t               item
);

    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  count_next;
    logic [POS_W-1:0]  elem_idx;
    logic [SIZE_W-1:0] n_elems;
    logic [SIZE_W-1:0] size_m1;
    logic              is_elem;
    logic              vec_done;
    logic              vec_flush;
    logic              vec_end;

    // element position, restarting when the count is stale for the size
    always_comb
    begin
        is_elem   = (mode == MODE_ELEM);
        elem_idx  = ({1'b0, count_reg} >= cfg.size) ? '0 : count_reg;
        n_elems   = {1'b0, elem_idx} + 4'd1;
        size_m1   = cfg.size - 4'd1;
        vec_done  = is_elem && (n_elems == cfg.size);
        vec_flush = is_elem && !vec_done && stream_last;
        vec_end   = vec_done || vec_flush;
    end

    // classified item
    always_comb
    begin
        item.mode        = mode;
        item.coeff_index = coeff_index;
        item.value       = value;
        item.elem_idx    = elem_idx;
        item.done        = vec_done;
        item.flush       = vec_flush;
        item.last_pos    = vec_done ? size_m1[POS_W-1:0] : elem_idx;
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (accept && is_elem)
        begin
            count_next = vec_end ? '0 : n_elems[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `FMVS_ASSERT_NEXT(a_count_restart, clk, rst_n, accept && vec_end, count_reg == '0)

endmodule

// ===== hw/rtl/fmvs_queue.sv =====
// short item queue between front and back
`include "fixed_matrix_vector_stream_unit_defines.svh"

module fmvs_queue
    import fmvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  fmvs_item_t wr_item,
    output logic       full,
    input  logic       rd_en,
    output fmvs_item_t rd_item,
    output logic       empty
);

    fmvs_item_t          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `FMVS_ASSERT_IMPLY(a_no_write_when_full, clk, rst_n, wr_en, !full)
    `FMVS_ASSERT_IMPLY(a_no_read_when_empty, clk, rst_n, rd_en, !empty)

endmodule

// ===== hw/rtl/fmvs_back.sv =====
// back: coefficient memories, per-lane multipliers and accumulators
`include "fixed_matrix_vector_stream_unit_defines.svh"

module fmvs_back
    import fmvs_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fmvs_cfg_t                        cfg,
    input  logic                             q_empty,
    input  fmvs_item_t                       q_item,
    output logic                             q_pop,
    input  logic                             cap_ready,
    output fmvs_done_t                       done,
    output logic [MAX_DIM-1:0][ACC_W-1:0]    acc
);

    logic       adv;
    logic       coeff_wr;
    logic       elem_rd;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s2_valid_reg;
    logic       s2_valid_next;
    fmvs_item_t s1_item_reg;
    fmvs_item_t s2_item_reg;
    fmvs_done_t done_reg;
    fmvs_done_t done_next;

    // whole pipeline holds while a finished vector waits for the result stage
    assign adv      = !done_reg.valid || cap_ready;
    assign q_pop    = adv && !q_empty;
    assign coeff_wr = q_pop && (q_item.mode == MODE_COEFF);
    assign elem_rd  = q_pop && (q_item.mode == MODE_ELEM);
    assign done     = done_reg;

    // stage valids and finished-vector handoff
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        done_next     = done_reg;
        if (adv)
        begin
            s1_valid_next      = elem_rd;
            s2_valid_next      = s1_valid_reg;
            done_next.valid    = s2_valid_reg && (s2_item_reg.done || s2_item_reg.flush);
            done_next.flush    = s2_item_reg.flush;
            done_next.last_pos = s2_item_reg.last_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            done_reg     <= done_next;
        end
    end

    // item fields following the lanes
    always_ff @(posedge clk)
    begin
        if (elem_rd)
        begin
            s1_item_reg <= q_item;
        end
        if (adv)
        begin
            s2_item_reg <= s1_item_reg;
        end
    end

    // one lane per output element
    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_lane
        localparam logic [POS_W-1:0] LANE = POS_W'(j);

        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic [COEFF_AW:0]        pos;
        logic [DATA_W-1:0]        coeff_mem [COEFF_DEPTH];
        logic [DATA_W-1:0]        rd_data_reg;
        logic signed [ACC_W-1:0]  prod_reg;
        logic [ACC_W-1:0]         acc_reg;
        logic [ACC_W-1:0]         acc_base;

        // flat coefficient address for this lane
        assign row = cfg.transpose ? LANE : q_item.elem_idx;
        assign col = cfg.transpose ? q_item.elem_idx : LANE;
        assign pos = (COEFF_AW+1)'(row) * (COEFF_AW+1)'(cfg.size) + (COEFF_AW+1)'(col);

        // lane copy of the coefficient store
        always_ff @(posedge clk)
        begin
            if (coeff_wr)
            begin
                coeff_mem[q_item.coeff_index] <= q_item.value;
            end
            if (elem_rd)
            begin
                rd_data_reg <= coeff_mem[pos[COEFF_AW-1:0]];
            end
        end

        // product
        always_ff @(posedge clk)
        begin
            if (adv && s1_valid_reg)
            begin
                prod_reg <= $signed(rd_data_reg) * $signed(s1_item_reg.value);
            end
        end

        // accumulate, first element of a vector starts from zero
        assign acc_base = (s2_item_reg.elem_idx == '0) ? '0 : acc_reg;

        always_ff @(posedge clk)
        begin
            if (adv && s2_valid_reg)
            begin
                acc_reg <= acc_base + prod_reg;
            end
        end

        assign acc[j] = acc_reg;
    end

    `FMVS_ASSERT_NEXT(a_done_held_on_stall, clk, rst_n, done_reg.valid && !cap_ready, done_reg.valid && $stable(done_reg.last_pos))

endmodule

// ===== hw/rtl/fmvs_emit.sv =====
// result stage: captures a finished vector and hands out its elements
`include "fixed_matrix_vector_stream_unit_defines.svh"

module fmvs_emit
    import fmvs_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmvs_done_t                    done,
    input  logic [MAX_DIM-1:0][ACC_W-1:0] acc,
    output logic                          cap_ready,
    input  logic                          pop,
    output logic                          empty,
    output logic signed [DATA_W-1:0]      result_value,
    output logic [POS_W-1:0]              result_position,
    output logic                          result_last
);

    logic [MAX_DIM-1:0][DATA_W-1:0] snap_reg;
    logic [MAX_DIM-1:0][DATA_W-1:0] snap_next;
    logic                           valid_reg;
    logic                           valid_next;
    logic [POS_W-1:0]               pos_reg;
    logic [POS_W-1:0]               pos_next;
    logic [POS_W-1:0]               last_pos_reg;
    logic [POS_W-1:0]               last_pos_next;
    logic                           is_last;
    logic                           take;
    logic                           capture;

    assign is_last         = (pos_reg == last_pos_reg);
    assign take            = valid_reg && pop;
    assign cap_ready       = !valid_reg || (take && is_last);
    assign capture         = done.valid && cap_ready;
    assign empty           = !valid_reg;
    assign result_value    = snap_reg[0];
    assign result_position = pos_reg;
    assign result_last     = is_last;

    // shift out on pop, load a new vector when empty or when the last item leaves
    always_comb
    begin
        valid_next    = valid_reg;
        pos_next      = pos_reg;
        last_pos_next = last_pos_reg;
        snap_next     = snap_reg;
        if (take)
        begin
            pos_next = pos_reg + 3'd1;
            for (int k = 0; k < MAX_DIM - 1; k++)
            begin
                snap_next[k] = snap_reg[k+1];
            end
            if (is_last)
            begin
                valid_next = 1'b0;
            end
        end
        if (capture)
        begin
            valid_next    = 1'b1;
            pos_next      = '0;
            last_pos_next = done.last_pos;
            for (int k = 0; k < MAX_DIM; k++)
            begin
                snap_next[k] = done.flush ? '0 : scale_sat(acc[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pos_reg      <= '0;
            last_pos_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            pos_reg      <= pos_next;
            last_pos_reg <= last_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    `FMVS_ASSERT_NEXT(a_pos_steps, clk, rst_n, take && !is_last, valid_reg && (pos_reg == $past(pos_reg) + 3'd1))
    `FMVS_ASSERT_IMPLY(a_pos_in_range, clk, rst_n, valid_reg, pos_reg <= last_pos_reg)

endmodule

// ===== hw/rtl/fixed_matrix_vector_stream_unit.sv =====
// A completing element passes the queue, read, product, accumulate and handoff registers.
// Throughput: one item per cycle; a finished vector leaves one element per cycle.
// The input side stalls only when the 4-entry item queue fills, which happens when the
// single result snapshot is still being popped as the next vector completes.
// Reset (rst_n low, asynchronous) empties queue and pipeline, size 4, transpose off;
// the coefficient store is not cleared and reads as unknown until written.
module fixed_matrix_vector_stream_unit
    import fmvs_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     mode,
    input  logic [COEFF_AW-1:0]      coeff_index,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     stream_last,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] result_value,
    output logic [POS_W-1:0]         result_position,
    output logic                     result_last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

    logic [SIZE_W-1:0]             size_reg;
    logic                          transpose_reg;
    fmvs_cfg_t                     cfg;
    logic                          accept;
    fmvs_item_t                    front_item;
    fmvs_item_t                    q_item;
    logic                          q_empty;
    logic                          q_pop;
    logic                          cap_ready;
    fmvs_done_t                    done;
    logic [MAX_DIM-1:0][ACC_W-1:0] acc;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            transpose_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE_IN_USE: size_reg      <= cfg_data[SIZE_W-1:0];
                CFG_TRANSPOSE:   transpose_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // effective size clamped to one through the lane count
    always_comb
    begin
        if (size_reg == '0)
        begin
            cfg.size = 4'd1;
        end
        else if (size_reg > MAX_SIZE)
        begin
            cfg.size = MAX_SIZE;
        end
        else
        begin
            cfg.size = size_reg;
        end
        cfg.transpose = transpose_reg;
    end

    fmvs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .coeff_index (coeff_index),
        .value       (value),
        .stream_last (stream_last),
        .cfg         (cfg),
        .item        (front_item)
    );

    fmvs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_item (front_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    fmvs_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cap_ready (cap_ready),
        .done      (done),
        .acc       (acc)
    );

    fmvs_emit #(
        .MAX_DIM (MAX_DIM)
    ) u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .done            (done),
        .acc             (acc),
        .cap_ready       (cap_ready),
        .pop             (pop),
        .empty           (empty),
        .result_value    (result_value),
        .result_position (result_position),
        .result_last     (result_last)
    );

endmodule
